FILE: rtl/spiee_pkg.sv
// Shared codes for the SPI EEPROM byte sequencer: request codes, result kinds,
// EEPROM opcodes and sequencer phase codes.
// No dependencies.
package spiee_pkg;

  // Request codes on the input channel
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_DONE  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_XFER  = 2'd0;
  localparam logic [1:0] KIND_WDONE = 2'd1;
  localparam logic [1:0] KIND_RDONE = 2'd2;

  // 25xx opcodes
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_WRITE = 8'h02;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_DUMMY = 8'h00;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_W_WREN  = 4'd1;
  localparam logic [3:0] PH_W_CMD   = 4'd2;
  localparam logic [3:0] PH_W_AHI   = 4'd3;
  localparam logic [3:0] PH_W_ALO   = 4'd4;
  localparam logic [3:0] PH_W_DATA  = 4'd5;
  localparam logic [3:0] PH_W_RDSR  = 4'd6;
  localparam logic [3:0] PH_W_STAT  = 4'd7;
  localparam logic [3:0] PH_R_CMD   = 4'd8;
  localparam logic [3:0] PH_R_AHI   = 4'd9;
  localparam logic [3:0] PH_R_ALO   = 4'd10;
  localparam logic [3:0] PH_R_DUMMY = 4'd11;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mosi_byte;
    logic       release_select;
    logic [7:0] read_data;
  } result_t;

endpackage

FILE: rtl/spi_eeprom_byte_sequencer.sv
// Command sequencer for a 25xx-style SPI EEPROM; sits above a byte shifter.
// Depends on spiee_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): read request, write request, or a
//   byte-transfer-complete event carrying the byte received on MISO.
//   Result channel (out_valid / out_stall): a byte to shift out (with a flag
//   to release chip select after it), a write-finished notice, or the byte
//   returned by a read. Each request gives zero or one result.
//   Requests while a transfer sequence is running, completions while idle and
//   unknown codes are dropped without a result.
//   A request passes through the input register, then the result register,
//   before its result is valid; a receiver stall can hold it in the input
//   register. Throughput: one request per cycle while the receiver does not
//   stall; the phase machine advances in a single pass between the input
//   register and the result register.
//   When the receiver stalls, the result register holds its value and the
//   input register fills; in_stall rises only when both are occupied.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   sequencer to idle.
module spi_eeprom_byte_sequencer #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [11:0] in_address,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_miso_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_mosi_byte,
  output logic       out_release_select,
  output logic [7:0] out_read_data
);

  localparam logic [19:0] CAP = 20'(CAPACITY);

  // Input register
  logic        in_vld_r;
  logic [1:0]  cmd_r;
  logic [11:0] addr_r;
  logic [7:0]  wdat_r;
  logic [7:0]  miso_r;

  // Sequencer state
  logic [3:0]  phase_r, phase_nxt;
  logic [11:0] held_address_r, held_address_nxt;
  logic [7:0]  held_data_r, held_data_nxt;

  // Result register
  logic                 out_vld_r;
  spiee_pkg::result_t   res_r;
  spiee_pkg::result_t   res_nxt;
  logic                 res_hit;

  logic        advance;
  logic [19:0] addr_mod;

  // Input register moves on when the result register is free or draining
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
      wdat_r <= in_write_data;
      miso_r <= in_miso_byte;
    end
  end

  // Address modulo capacity: for CAPACITY of 256 or more the quotient is below 16, so four restoring steps
  always_comb begin
    addr_mod = {8'd0, addr_r};
    for (int k = 3; k >= 0; k--) begin
      if (addr_mod >= (CAP << k)) begin
        addr_mod = addr_mod - (CAP << k);
      end
    end
  end

  // Phase machine, one event per pass
  always_comb begin
    phase_nxt        = phase_r;
    held_address_nxt = held_address_r;
    held_data_nxt    = held_data_r;
    res_hit          = 1'b0;
    res_nxt          = '0;
    res_nxt.kind     = spiee_pkg::KIND_XFER;
    if (phase_r == spiee_pkg::PH_IDLE) begin
      if (cmd_r == spiee_pkg::CMD_READ || cmd_r == spiee_pkg::CMD_WRITE) begin
        held_address_nxt = addr_mod[11:0];
        held_data_nxt    = wdat_r;
        res_hit          = 1'b1;
        if (cmd_r == spiee_pkg::CMD_WRITE) begin
          phase_nxt              = spiee_pkg::PH_W_WREN;
          res_nxt.mosi_byte      = spiee_pkg::OP_WREN;
          res_nxt.release_select = 1'b1;
        end else begin
          phase_nxt         = spiee_pkg::PH_R_CMD;
          res_nxt.mosi_byte = spiee_pkg::OP_READ;
        end
      end
    end else if (cmd_r == spiee_pkg::CMD_DONE) begin
      res_hit = 1'b1;
      unique case (phase_r)
        spiee_pkg::PH_W_WREN: begin
          phase_nxt         = spiee_pkg::PH_W_CMD;
          res_nxt.mosi_byte = spiee_pkg::OP_WRITE;
        end
        spiee_pkg::PH_W_CMD: begin
          phase_nxt         = spiee_pkg::PH_W_AHI;
          res_nxt.mosi_byte = {4'd0, held_address_r[11:8]};
        end
        spiee_pkg::PH_W_AHI: begin
          phase_nxt         = spiee_pkg::PH_W_ALO;
          res_nxt.mosi_byte = held_address_r[7:0];
        end
        spiee_pkg::PH_W_ALO: begin
          phase_nxt              = spiee_pkg::PH_W_DATA;
          res_nxt.mosi_byte      = held_data_r;
          res_nxt.release_select = 1'b1;
        end
        spiee_pkg::PH_W_DATA: begin
          phase_nxt         = spiee_pkg::PH_W_RDSR;
          res_nxt.mosi_byte = spiee_pkg::OP_RDSR;
        end
        spiee_pkg::PH_W_RDSR: begin
          phase_nxt              = spiee_pkg::PH_W_STAT;
          res_nxt.mosi_byte      = spiee_pkg::OP_DUMMY;
          res_nxt.release_select = 1'b1;
        end
        spiee_pkg::PH_W_STAT: begin
          // write-in-progress bit set: poll again
          if (miso_r[0]) begin
            phase_nxt         = spiee_pkg::PH_W_RDSR;
            res_nxt.mosi_byte = spiee_pkg::OP_RDSR;
          end else begin
            phase_nxt    = spiee_pkg::PH_IDLE;
            res_nxt.kind = spiee_pkg::KIND_WDONE;
          end
        end
        spiee_pkg::PH_R_CMD: begin
          phase_nxt         = spiee_pkg::PH_R_AHI;
          res_nxt.mosi_byte = {4'd0, held_address_r[11:8]};
        end
        spiee_pkg::PH_R_AHI: begin
          phase_nxt         = spiee_pkg::PH_R_ALO;
          res_nxt.mosi_byte = held_address_r[7:0];
        end
        spiee_pkg::PH_R_ALO: begin
          phase_nxt              = spiee_pkg::PH_R_DUMMY;
          res_nxt.mosi_byte      = spiee_pkg::OP_DUMMY;
          res_nxt.release_select = 1'b1;
        end
        spiee_pkg::PH_R_DUMMY: begin
          phase_nxt         = spiee_pkg::PH_IDLE;
          res_nxt.kind      = spiee_pkg::KIND_RDONE;
          res_nxt.read_data = miso_r;
        end
        default: begin
          phase_nxt = spiee_pkg::PH_IDLE;
          res_hit   = 1'b0;
        end
      endcase
    end
  end

  // State update when the buffered request is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= spiee_pkg::PH_IDLE;
      held_address_r <= '0;
      held_data_r    <= '0;
    end else if (in_vld_r && advance) begin
      phase_r        <= phase_nxt;
      held_address_r <= held_address_nxt;
      held_data_r    <= held_data_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r && res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r && res_hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_kind           = res_r.kind;
  assign out_mosi_byte      = res_r.mosi_byte;
  assign out_release_select = res_r.release_select;
  assign out_read_data      = res_r.read_data;

endmodule

FILE: verif/tb_spi_eeprom_byte_sequencer.sv
`timescale 1ns / 100ps
// Self-checking bench for spi_eeprom_byte_sequencer: queue-fed driver, clocked monitor,
// and an in-bench copy of the EEPROM command sequence used to predict each result.
// Depends on spiee_pkg and the sequencer RTL.
module tb_spi_eeprom_byte_sequencer;

  localparam int unsigned CAPACITY = 4096;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;
  // Code 3 is not a defined request; the block must drop it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] WIP_MASK = 8'h01;

  typedef struct {
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [7:0]  miso_byte;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = spiee_pkg::CMD_DONE;
  logic [11:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [7:0]  in_miso_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_mosi_byte;
  logic        out_release_select;
  logic [7:0]  out_read_data;

  request_t            pending_requests[$];
  spiee_pkg::result_t  expected_results[$];

  // Sequencer state as predicted by the bench
  logic [3:0]  seq_phase = spiee_pkg::PH_IDLE;
  logic [11:0] seq_address = '0;
  logic [7:0]  seq_data = '0;

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  logic req_taken = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int writes_done = 0;
  int reads_done = 0;
  int busy_polls = 0;
  int queued_items = 0;

  spi_eeprom_byte_sequencer #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_address(in_address),
    .in_write_data(in_write_data),
    .in_miso_byte(in_miso_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_mosi_byte(out_mosi_byte),
    .out_release_select(out_release_select),
    .out_read_data(out_read_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Advance the predicted sequencer by one accepted request
  task automatic predict_sequence_step(input logic [1:0] cmd, input logic [11:0] addr,
                                       input logic [7:0] wdat, input logic [7:0] miso);
    spiee_pkg::result_t r;
    logic    emit;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    addr_hi = {4'b0000, seq_address[11:8]};
    addr_lo = seq_address[7:0];
    r = '0;
    r.kind = spiee_pkg::KIND_XFER;
    emit = 1'b1;
    if (seq_phase == spiee_pkg::PH_IDLE) begin
      if (cmd == spiee_pkg::CMD_READ || cmd == spiee_pkg::CMD_WRITE) begin
        seq_address = 12'(addr % CAPACITY);
        seq_data = wdat;
        if (cmd == spiee_pkg::CMD_WRITE) begin
          seq_phase = spiee_pkg::PH_W_WREN;
          r.mosi_byte = spiee_pkg::OP_WREN;
          r.release_select = 1'b1;
        end else begin
          seq_phase = spiee_pkg::PH_R_CMD;
          r.mosi_byte = spiee_pkg::OP_READ;
        end
      end else begin
        emit = 1'b0;
      end
    end else if (cmd != spiee_pkg::CMD_DONE) begin
      // busy: requests and unknown codes are dropped
      emit = 1'b0;
    end else begin
      case (seq_phase)
        spiee_pkg::PH_W_WREN: begin
          seq_phase = spiee_pkg::PH_W_CMD;
          r.mosi_byte = spiee_pkg::OP_WRITE;
        end
        spiee_pkg::PH_W_CMD: begin
          seq_phase = spiee_pkg::PH_W_AHI;
          r.mosi_byte = addr_hi;
        end
        spiee_pkg::PH_W_AHI: begin
          seq_phase = spiee_pkg::PH_W_ALO;
          r.mosi_byte = addr_lo;
        end
        spiee_pkg::PH_W_ALO: begin
          seq_phase = spiee_pkg::PH_W_DATA;
          r.mosi_byte = seq_data;
          r.release_select = 1'b1;
        end
        spiee_pkg::PH_W_DATA: begin
          seq_phase = spiee_pkg::PH_W_RDSR;
          r.mosi_byte = spiee_pkg::OP_RDSR;
        end
        spiee_pkg::PH_W_RDSR: begin
          seq_phase = spiee_pkg::PH_W_STAT;
          r.mosi_byte = spiee_pkg::OP_DUMMY;
          r.release_select = 1'b1;
        end
        spiee_pkg::PH_W_STAT: begin
          if ((miso & WIP_MASK) != 0) begin
            seq_phase = spiee_pkg::PH_W_RDSR;
            r.mosi_byte = spiee_pkg::OP_RDSR;
            busy_polls++;
          end else begin
            seq_phase = spiee_pkg::PH_IDLE;
            r.kind = spiee_pkg::KIND_WDONE;
          end
        end
        spiee_pkg::PH_R_CMD: begin
          seq_phase = spiee_pkg::PH_R_AHI;
          r.mosi_byte = addr_hi;
        end
        spiee_pkg::PH_R_AHI: begin
          seq_phase = spiee_pkg::PH_R_ALO;
          r.mosi_byte = addr_lo;
        end
        spiee_pkg::PH_R_ALO: begin
          seq_phase = spiee_pkg::PH_R_DUMMY;
          r.mosi_byte = spiee_pkg::OP_DUMMY;
          r.release_select = 1'b1;
        end
        spiee_pkg::PH_R_DUMMY: begin
          seq_phase = spiee_pkg::PH_IDLE;
          r.kind = spiee_pkg::KIND_RDONE;
          r.read_data = miso;
        end
        default: begin
          seq_phase = spiee_pkg::PH_IDLE;
          emit = 1'b0;
        end
      endcase
    end
    if (emit) expected_results.push_back(r);
  endtask

  // Request queue builders; every queued request counts toward the item total
  task automatic push_req(input logic [1:0] cmd, input logic [11:0] addr,
                          input logic [7:0] wdat, input logic [7:0] miso);
    request_t q;
    q.command = cmd;
    q.address = addr;
    q.write_data = wdat;
    q.miso_byte = miso;
    pending_requests.push_back(q);
    queued_items++;
  endtask

  task automatic push_done(input logic [7:0] miso);
    push_req(spiee_pkg::CMD_DONE, 12'($urandom), 8'($urandom), miso);
  endtask

  // Noise requests; the block drops them when they arrive while a sequence is running
  task automatic maybe_busy_noise(input int pct);
    if ($urandom_range(99) < pct) begin
      case ($urandom_range(2))
        0: push_req(spiee_pkg::CMD_READ, 12'($urandom), 8'($urandom), 8'($urandom));
        1: push_req(spiee_pkg::CMD_WRITE, 12'($urandom), 8'($urandom), 8'($urandom));
        default: push_req(CMD_UNUSED, 12'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // Write: WREN, WRITE, address, data, RDSR/status polls until WIP clears
  task automatic queue_write(input logic [11:0] addr, input logic [7:0] data,
                             input int polls, input int noise_pct);
    push_req(spiee_pkg::CMD_WRITE, addr, data, 8'($urandom));
    repeat (6) begin
      maybe_busy_noise(noise_pct);
      push_done(8'($urandom));
    end
    repeat (polls) begin
      maybe_busy_noise(noise_pct);
      push_done(8'($urandom) | WIP_MASK);
      maybe_busy_noise(noise_pct);
      push_done(8'($urandom));
    end
    maybe_busy_noise(noise_pct);
    push_done(8'($urandom) & ~WIP_MASK);
  endtask

  // Read: READ, address, dummy, returned byte
  task automatic queue_read(input logic [11:0] addr, input int noise_pct);
    push_req(spiee_pkg::CMD_READ, addr, 8'($urandom), 8'($urandom));
    repeat (4) begin
      maybe_busy_noise(noise_pct);
      push_done(8'($urandom));
    end
  endtask

  function automatic logic [11:0] pick_address();
    case ($urandom_range(9))
      0: return 12'h000;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic queue_random_traffic(input int target);
    int stop_at;
    int cut;
    stop_at = queued_items + target;
    while (queued_items < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          queue_write(pick_address(), ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom),
                      $urandom_range(3), 8);
        9, 10, 11, 12, 13, 14, 15:
          queue_read(pick_address(), 8);
        16: begin
          // stray traffic while idle
          if ($urandom_range(1) == 0) push_done(8'($urandom));
          else push_req(CMD_UNUSED, 12'($urandom), 8'($urandom), 8'($urandom));
        end
        default: begin
          // broken sequence: cut short, then flush with even status bytes
          push_req($urandom_range(1) ? spiee_pkg::CMD_WRITE : spiee_pkg::CMD_READ,
                   12'($urandom), 8'($urandom), 8'($urandom));
          cut = $urandom_range(5);
          repeat (cut) push_done(8'($urandom));
          maybe_busy_noise(100);
          repeat (8) push_done(8'($urandom) & ~WIP_MASK);
        end
      endcase
    end
  endtask

  // Driver: new request at the falling edge once the previous one is taken
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n && (!in_valid || req_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_command <= nxt.command;
        in_address <= nxt.address;
        in_write_data <= nxt.write_data;
        in_miso_byte <= nxt.miso_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check results and predict from accepted requests at the rising edge
  always @(posedge clk) begin
    spiee_pkg::result_t want;
    req_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked_count++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d mosi=%02h rel=%0b rd=%02h",
                                    out_kind, out_mosi_byte, out_release_select,
                                    out_read_data));
        end else begin
          want = expected_results.pop_front();
          if (out_kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
          if (out_mosi_byte != want.mosi_byte)
            report_mismatch($sformatf("mosi_byte %02h, expected %02h",
                                      out_mosi_byte, want.mosi_byte));
          if (out_release_select != want.release_select)
            report_mismatch($sformatf("release_select %0b, expected %0b",
                                      out_release_select, want.release_select));
          if (out_read_data != want.read_data)
            report_mismatch($sformatf("read_data %02h, expected %02h",
                                      out_read_data, want.read_data));
          if (want.kind == spiee_pkg::KIND_WDONE) writes_done++;
          if (want.kind == spiee_pkg::KIND_RDONE) reads_done++;
        end
      end
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        accepted_count++;
        predict_sequence_step(in_command, in_address, in_write_data, in_miso_byte);
      end
    end
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    // directed: address/data extremes, busy drops, idle drops, status polling
    queue_write(12'hFFF, 8'hFF, 1, 0);
    push_req(spiee_pkg::CMD_READ, 12'h000, 8'h00, 8'h00);
    push_req(spiee_pkg::CMD_WRITE, 12'hFFF, 8'hFF, 8'hFF);
    push_req(CMD_UNUSED, 12'hFFF, 8'hFF, 8'hFF);
    repeat (3) push_done(8'($urandom));
    push_done(8'hFF);
    push_done(8'h5A);
    push_req(CMD_UNUSED, 12'h000, 8'h00, 8'h00);
    queue_write(12'h000, 8'h00, 0, 0);

    send_gap_pct = 14;
    recv_stall_pct = 80;
    queue_random_traffic(205);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    send_gap_pct = 80;
    recv_stall_pct = 14;
    queue_random_traffic(205);

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    queue_random_traffic(200);

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d writes (%0d busy polls), %0d reads.",
             accepted_count, checked_count, writes_done, busy_polls, reads_done);
    $display("Traffic ran with sender gaps, receiver stalls, then back to back.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
